FILE: hdl/tnb_pkg.sv
package tnb_pkg;

    localparam int COORD_BITS       = 24;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int NORMAL_BITS      = 16;
    localparam int COLOR_BITS       = 16;

    localparam int OP_W  = 4;
    localparam int CNT_W = 5;

    localparam logic [OP_W-1:0] OP_NONE  = 4'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 4'd1;
    localparam logic [OP_W-1:0] OP_BOX   = 4'd2;
    localparam logic [OP_W-1:0] OP_MUL   = 4'd3;
    localparam logic [OP_W-1:0] OP_MAG   = 4'd4;
    localparam logic [OP_W-1:0] OP_NRM_R = 4'd5;
    localparam logic [OP_W-1:0] OP_NRM_L = 4'd6;
    localparam logic [OP_W-1:0] OP_SQR   = 4'd7;
    localparam logic [OP_W-1:0] OP_SQRI  = 4'd8;
    localparam logic [OP_W-1:0] OP_SQRT  = 4'd9;
    localparam logic [OP_W-1:0] OP_DIVI  = 4'd10;
    localparam logic [OP_W-1:0] OP_DIV   = 4'd11;
    localparam logic [OP_W-1:0] OP_OUT   = 4'd12;

    localparam logic [CNT_W-1:0] MUL_LAST  = 5'd6;
    localparam logic [CNT_W-1:0] SQR_LAST  = 5'd3;
    localparam logic [CNT_W-1:0] SQRT_LAST = 5'd31;
    localparam logic [CNT_W-1:0] DIV_LAST  = 5'(NORMAL_FRAC_BITS + 1);

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [CNT_W-1:0] cnt;
    } t_cmd;

    typedef struct packed {
        logic big;
        logic top;
        logic zero;
    } t_stat;

endpackage

FILE: hdl/tnb_ctrl.sv
module tnb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_stall,
    input  tnb_pkg::t_stat i_stat,
    output logic          o_stall,
    output logic          o_valid,
    output tnb_pkg::t_cmd o_cmd
);
    import tnb_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BOX  = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_MAG  = 4'd3;
    localparam logic [3:0] S_NORM = 4'd4;
    localparam logic [3:0] S_SQR  = 4'd5;
    localparam logic [3:0] S_SQRI = 4'd6;
    localparam logic [3:0] S_SQRT = 4'd7;
    localparam logic [3:0] S_DIVI = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_oval, n_oval;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt + 1'b1;
        n_oval     = r_oval && i_stall;
        o_cmd.op   = OP_NONE;
        o_cmd.cnt  = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (i_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_BOX;
                end
            end
            S_BOX: begin
                o_cmd.op = OP_BOX;
                n_cnt    = '0;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = OP_MUL;
                if (r_cnt == MUL_LAST) n_state = S_MAG;
            end
            S_MAG: begin
                o_cmd.op = OP_MAG;
                n_state  = S_NORM;
            end
            S_NORM: begin
                n_cnt = '0;
                if (i_stat.big) begin
                    o_cmd.op = OP_NRM_R;
                end else if (!i_stat.zero && !i_stat.top) begin
                    o_cmd.op = OP_NRM_L;
                end else begin
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                o_cmd.op = OP_SQR;
                if (r_cnt == SQR_LAST) n_state = S_SQRI;
            end
            S_SQRI: begin
                o_cmd.op = OP_SQRI;
                n_cnt    = '0;
                n_state  = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.op = OP_SQRT;
                if (r_cnt == SQRT_LAST) n_state = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.op = OP_DIVI;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                if (r_cnt == DIV_LAST) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_oval || !i_stall) begin
                    o_cmd.op = OP_OUT;
                    n_oval   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_oval  <= n_oval;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_oval;

endmodule

FILE: hdl/tnb_dp.sv
module tnb_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tnb_pkg::t_cmd                         i_cmd,
    input  logic                                  i_start_mesh,
    input  logic signed [tnb_pkg::COORD_BITS-1:0] i_ax,
    input  logic signed [tnb_pkg::COORD_BITS-1:0] i_ay,
    input  logic signed [tnb_pkg::COORD_BITS-1:0] i_az,
    input  logic signed [tnb_pkg::COORD_BITS-1:0] i_bx,
    input  logic signed [tnb_pkg::COORD_BITS-1:0] i_by_coord,
    input  logic signed [tnb_pkg::COORD_BITS-1:0] i_bz,
    input  logic signed [tnb_pkg::COORD_BITS-1:0] i_cx,
    input  logic signed [tnb_pkg::COORD_BITS-1:0] i_cy,
    input  logic signed [tnb_pkg::COORD_BITS-1:0] i_cz,
    output tnb_pkg::t_stat                        o_stat,
    output logic signed [tnb_pkg::NORMAL_BITS-1:0] o_normal_x,
    output logic signed [tnb_pkg::NORMAL_BITS-1:0] o_normal_y,
    output logic signed [tnb_pkg::NORMAL_BITS-1:0] o_normal_z,
    output logic [tnb_pkg::COLOR_BITS-1:0]        o_color_r,
    output logic [tnb_pkg::COLOR_BITS-1:0]        o_color_g,
    output logic [tnb_pkg::COLOR_BITS-1:0]        o_color_b,
    output logic signed [tnb_pkg::COORD_BITS-1:0] o_box_min_x,
    output logic signed [tnb_pkg::COORD_BITS-1:0] o_box_min_y,
    output logic signed [tnb_pkg::COORD_BITS-1:0] o_box_min_z,
    output logic signed [tnb_pkg::COORD_BITS-1:0] o_box_max_x,
    output logic signed [tnb_pkg::COORD_BITS-1:0] o_box_max_y,
    output logic signed [tnb_pkg::COORD_BITS-1:0] o_box_max_z
);
    import tnb_pkg::*;

    localparam int CW    = COORD_BITS;
    localparam int F     = NORMAL_FRAC_BITS;
    localparam int DW    = CW + 1;
    localparam int XW    = 2 * DW + 1;
    localparam int MW    = 31;
    localparam int MUL_W = (DW > MW + 1) ? DW : MW + 1;
    localparam int LW    = 2 * MW + 2;
    localparam int RW    = LW / 2;
    localparam int QW    = F + 2;
    localparam int NUM_W = MW + F + 1;

    localparam logic signed [CW-1:0] MAX_POS = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MAX_NEG = {1'b1, {(CW-1){1'b0}}};

    function automatic logic signed [CW-1:0] f_min(logic signed [CW-1:0] a,
                                                   logic signed [CW-1:0] b);
        return (b < a) ? b : a;
    endfunction

    function automatic logic signed [CW-1:0] f_max(logic signed [CW-1:0] a,
                                                   logic signed [CW-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [COLOR_BITS-1:0] f_col(logic [F:0] n, logic neg);
        logic [F+1:0]  t;
        logic [F+16:0] s;
        t = neg ? (((F+2)'(1) << F) - (F+2)'(n)) : (((F+2)'(1) << F) + (F+2)'(n));
        s = {t, 15'b0} >> F;
        return (s > (F+17)'(65535)) ? {COLOR_BITS{1'b1}} : s[COLOR_BITS-1:0];
    endfunction

    function automatic logic signed [NORMAL_BITS-1:0] f_nrm(logic [F:0] n, logic neg);
        logic signed [F+1:0] sn;
        sn = neg ? -$signed({1'b0, n}) : $signed({1'b0, n});
        return NORMAL_BITS'(sn);
    endfunction

    logic                 r_start;
    logic signed [CW-1:0] r_v [3][3];
    logic signed [CW-1:0] r_lo [3];
    logic signed [CW-1:0] r_hi [3];
    logic signed [DW-1:0] r_d1 [3];
    logic signed [DW-1:0] r_d2 [3];
    logic signed [2*MUL_W-1:0] r_prod;
    logic signed [XW-1:0] r_first;
    logic signed [XW-1:0] r_cr [3];
    logic [XW-1:0]        r_mag [3];
    logic                 r_neg [3];
    logic [LW-1:0]        r_len2;
    logic [LW-1:0]        r_sv, r_res, r_bit;
    logic [RW-1:0]        r_rem [3];
    logic [QW-1:0]        r_num [3];
    logic [QW-1:0]        r_q [3];

    logic signed [MUL_W-1:0] s_opa, s_opb;
    logic [XW-1:0]        s_all;
    logic [RW-1:0]        s_root;
    logic [LW-1:0]        s_trial;
    logic [2:0]           s_k;
    logic signed [XW-1:0] s_plow;

    assign s_all   = r_mag[0] | r_mag[1] | r_mag[2];
    assign o_stat.big  = |s_all[XW-1:MW];
    assign o_stat.top  = s_all[MW-1];
    assign o_stat.zero = (s_all == '0);
    assign s_root  = r_res[RW-1:0];
    assign s_trial = r_res + r_bit;
    assign s_k     = i_cmd.cnt[2:0] - 3'd1;
    assign s_plow  = r_prod[XW-1:0];

    always_comb begin
        s_opa = '0;
        s_opb = '0;
        if (i_cmd.op == OP_MUL) begin
            case (i_cmd.cnt[2:0])
                3'd0: begin s_opa = MUL_W'(r_d2[1]); s_opb = MUL_W'(r_d1[2]); end
                3'd1: begin s_opa = MUL_W'(r_d2[2]); s_opb = MUL_W'(r_d1[1]); end
                3'd2: begin s_opa = MUL_W'(r_d2[2]); s_opb = MUL_W'(r_d1[0]); end
                3'd3: begin s_opa = MUL_W'(r_d2[0]); s_opb = MUL_W'(r_d1[2]); end
                3'd4: begin s_opa = MUL_W'(r_d2[0]); s_opb = MUL_W'(r_d1[1]); end
                3'd5: begin s_opa = MUL_W'(r_d2[1]); s_opb = MUL_W'(r_d1[0]); end
                default: ;
            endcase
        end else begin
            case (i_cmd.cnt[1:0])
                2'd0: s_opa = $signed(MUL_W'(r_mag[0][MW-1:0]));
                2'd1: s_opa = $signed(MUL_W'(r_mag[1][MW-1:0]));
                2'd2: s_opa = $signed(MUL_W'(r_mag[2][MW-1:0]));
                default: ;
            endcase
            s_opb = s_opa;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= MAX_POS;
                r_hi[a] <= MAX_NEG;
            end
        end else if (i_cmd.op == OP_BOX) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= f_min(f_min(f_min(r_start ? MAX_POS : r_lo[a], r_v[0][a]),
                                       r_v[1][a]), r_v[2][a]);
                r_hi[a] <= f_max(f_max(f_max(r_start ? MAX_NEG : r_hi[a], r_v[0][a]),
                                       r_v[1][a]), r_v[2][a]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_start    <= i_start_mesh;
                r_v[0][0]  <= i_ax;
                r_v[0][1]  <= i_ay;
                r_v[0][2]  <= i_az;
                r_v[1][0]  <= i_bx;
                r_v[1][1]  <= i_by_coord;
                r_v[1][2]  <= i_bz;
                r_v[2][0]  <= i_cx;
                r_v[2][1]  <= i_cy;
                r_v[2][2]  <= i_cz;
            end
            OP_BOX: begin
                for (int a = 0; a < 3; a++) begin
                    r_d1[a] <= DW'(r_v[1][a]) - DW'(r_v[0][a]);
                    r_d2[a] <= DW'(r_v[2][a]) - DW'(r_v[0][a]);
                end
            end
            OP_MUL: begin
                r_prod <= s_opa * s_opb;
                if (i_cmd.cnt != '0) begin
                    if (!s_k[0]) begin
                        r_first <= s_plow;
                    end else begin
                        case (s_k[2:1])
                            2'd0: r_cr[0] <= r_first - s_plow;
                            2'd1: r_cr[1] <= r_first - s_plow;
                            default: r_cr[2] <= r_first - s_plow;
                        endcase
                    end
                end
            end
            OP_MAG: begin
                for (int a = 0; a < 3; a++) begin
                    r_neg[a] <= r_cr[a][XW-1];
                    r_mag[a] <= r_cr[a][XW-1] ? XW'(-r_cr[a]) : XW'(r_cr[a]);
                end
                r_len2 <= '0;
            end
            OP_NRM_R: begin
                for (int a = 0; a < 3; a++) r_mag[a] <= r_mag[a] >> 1;
            end
            OP_NRM_L: begin
                for (int a = 0; a < 3; a++) r_mag[a] <= r_mag[a] << 1;
            end
            OP_SQR: begin
                r_prod <= s_opa * s_opb;
                if (i_cmd.cnt != '0) r_len2 <= r_len2 + r_prod[LW-1:0];
            end
            OP_SQRI: begin
                r_sv  <= r_len2;
                r_res <= '0;
                r_bit <= LW'(1) << (LW - 2);
            end
            OP_SQRT: begin
                if (r_sv >= s_trial) begin
                    r_sv  <= r_sv - s_trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            OP_DIVI: begin
                for (int a = 0; a < 3; a++) begin
                    r_rem[a] <= RW'(({r_mag[a][MW-1:0], F'(0)} + NUM_W'(s_root >> 1)) >> QW);
                    r_num[a] <= QW'({r_mag[a][MW-1:0], F'(0)} + NUM_W'(s_root >> 1));
                    r_q[a]   <= '0;
                end
            end
            OP_DIV: begin
                for (int a = 0; a < 3; a++) begin
                    if ({r_rem[a], r_num[a][QW-1]} >= {1'b0, s_root}) begin
                        r_rem[a] <= RW'({r_rem[a], r_num[a][QW-1]} - {1'b0, s_root});
                        r_q[a]   <= {r_q[a][QW-2:0], 1'b1};
                    end else begin
                        r_rem[a] <= RW'({r_rem[a], r_num[a][QW-1]});
                        r_q[a]   <= {r_q[a][QW-2:0], 1'b0};
                    end
                    r_num[a] <= r_num[a] << 1;
                end
            end
            OP_OUT: begin
                o_normal_x  <= f_nrm((s_root == '0) ? '0 : r_q[0][F:0], r_neg[0]);
                o_normal_y  <= f_nrm((s_root == '0) ? '0 : r_q[1][F:0], r_neg[1]);
                o_normal_z  <= f_nrm((s_root == '0) ? '0 : r_q[2][F:0], r_neg[2]);
                o_color_r   <= f_col((s_root == '0) ? '0 : r_q[0][F:0], r_neg[0]);
                o_color_g   <= f_col((s_root == '0) ? '0 : r_q[1][F:0], r_neg[1]);
                o_color_b   <= f_col((s_root == '0) ? '0 : r_q[2][F:0], r_neg[2]);
                o_box_min_x <= r_lo[0];
                o_box_min_y <= r_lo[1];
                o_box_min_z <= r_lo[2];
                o_box_max_x <= r_hi[0];
                o_box_max_y <= r_hi[1];
                o_box_max_z <= r_hi[2];
            end
            default: ;
        endcase
    end

endmodule

FILE: hdl/triangle_normal_bbox_unit.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_start_mesh, nine vertex coordinates
// result    out        o_valid / i_stall  normal, colour, bounding box
//
// o_valid rises after an input transaction once the unit has run the 32-step square
// root and the 16-step dividers and the normalising shifter has moved the magnitudes
// (by no bits for a degenerate triangle, by up to 30 otherwise).
// Reset is synchronous and active low; it empties the result register and sets an
// empty bounding box.
// A result waiting under i_stall holds the next triangle at its final cycle.
module triangle_normal_bbox_unit (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic                                   i_start_mesh,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  i_ax,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  i_ay,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  i_az,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  i_bx,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  i_by_coord,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  i_bz,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  i_cx,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  i_cy,
    input  logic signed [tnb_pkg::COORD_BITS-1:0]  i_cz,
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic signed [tnb_pkg::NORMAL_BITS-1:0] o_normal_x,
    output logic signed [tnb_pkg::NORMAL_BITS-1:0] o_normal_y,
    output logic signed [tnb_pkg::NORMAL_BITS-1:0] o_normal_z,
    output logic [tnb_pkg::COLOR_BITS-1:0]         o_color_r,
    output logic [tnb_pkg::COLOR_BITS-1:0]         o_color_g,
    output logic [tnb_pkg::COLOR_BITS-1:0]         o_color_b,
    output logic signed [tnb_pkg::COORD_BITS-1:0]  o_box_min_x,
    output logic signed [tnb_pkg::COORD_BITS-1:0]  o_box_min_y,
    output logic signed [tnb_pkg::COORD_BITS-1:0]  o_box_min_z,
    output logic signed [tnb_pkg::COORD_BITS-1:0]  o_box_max_x,
    output logic signed [tnb_pkg::COORD_BITS-1:0]  o_box_max_y,
    output logic signed [tnb_pkg::COORD_BITS-1:0]  o_box_max_z
);
    import tnb_pkg::*;

    t_cmd  s_cmd;
    t_stat s_stat;

    tnb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .i_stat  (s_stat),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_cmd   (s_cmd)
    );

    tnb_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (s_cmd),
        .i_start_mesh (i_start_mesh),
        .i_ax         (i_ax),
        .i_ay         (i_ay),
        .i_az         (i_az),
        .i_bx         (i_bx),
        .i_by_coord   (i_by_coord),
        .i_bz         (i_bz),
        .i_cx         (i_cx),
        .i_cy         (i_cy),
        .i_cz         (i_cz),
        .o_stat       (s_stat),
        .o_normal_x   (o_normal_x),
        .o_normal_y   (o_normal_y),
        .o_normal_z   (o_normal_z),
        .o_color_r    (o_color_r),
        .o_color_g    (o_color_g),
        .o_color_b    (o_color_b),
        .o_box_min_x  (o_box_min_x),
        .o_box_min_y  (o_box_min_y),
        .o_box_min_z  (o_box_min_z),
        .o_box_max_x  (o_box_max_x),
        .o_box_max_y  (o_box_max_y),
        .o_box_max_z  (o_box_max_z)
    );

endmodule

FILE: hdl/tnb_checker.sv
module tnb_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_valid,
    input logic                                   o_stall,
    input logic                                   o_valid,
    input logic                                   i_stall,
    input logic signed [tnb_pkg::NORMAL_BITS-1:0] o_normal_x,
    input logic [tnb_pkg::COLOR_BITS-1:0]         o_color_r,
    input logic signed [tnb_pkg::COORD_BITS-1:0]  o_box_min_x,
    input logic signed [tnb_pkg::COORD_BITS-1:0]  o_box_max_x
);
    import tnb_pkg::*;

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("Result transaction dropped while stalled.");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_normal_x) && $stable(o_box_min_x))
        else $error("Stalled result changed.");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("Input not blocked after a transaction.");

    a_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_box_min_x <= o_box_max_x)
        else $error("Bounding box inverted.");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_normal_x == '0 |-> o_color_r == COLOR_BITS'(32768))
        else $error("Colour does not match a zero normal.");

endmodule

bind triangle_normal_bbox_unit tnb_checker u_tnb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_normal_x  (o_normal_x),
    .o_color_r   (o_color_r),
    .o_box_min_x (o_box_min_x),
    .o_box_max_x (o_box_max_x)
);
